@@ rtl/q2e_pkg.sv @@
// ---------------------------------------------------------------------------
// q2e_pkg
// Shared widths, side-band types and the arctangent table for the
// quaternion to euler code pipeline.
// ---------------------------------------------------------------------------
package q2e_pkg;

  // widths of the fixed-point datapath
  localparam int QW        = 16;  // quaternion component
  localparam int PW        = 32;  // product of two components
  localparam int VW        = 34;  // atan2 numerator / denominator
  localparam int SW        = 30;  // clamped pitch term
  localparam int NW        = 58;  // square root radicand and remainder
  localparam int RW        = 29;  // square root result
  localparam int CW        = 38;  // cordic vector
  localparam int AW        = 34;  // binary angle, full turn = 2^32
  localparam int ISQ_STEPS = 29;  // one result bit per step
  localparam int LANES     = 3;   // roll, pitch, yaw
  localparam int ATAN_LEN  = 24;

  // lane order inside the cordic
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // terms that travel beside the square root
  typedef struct packed {
    logic signed [VW-1:0] roll_num;
    logic signed [VW-1:0] roll_den;
    logic signed [VW-1:0] yaw_num;
    logic signed [VW-1:0] yaw_den;
    logic signed [SW-1:0] pitch_s;
  } side_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AW-1:0] t;
    unique case (i)
      5'd0:    t = 34'sd536870912;
      5'd1:    t = 34'sd316933406;
      5'd2:    t = 34'sd167458907;
      5'd3:    t = 34'sd85004756;
      5'd4:    t = 34'sd42667331;
      5'd5:    t = 34'sd21354465;
      5'd6:    t = 34'sd10679838;
      5'd7:    t = 34'sd5340245;
      5'd8:    t = 34'sd2670163;
      5'd9:    t = 34'sd1335087;
      5'd10:   t = 34'sd667544;
      5'd11:   t = 34'sd333772;
      5'd12:   t = 34'sd166886;
      5'd13:   t = 34'sd83443;
      5'd14:   t = 34'sd41722;
      5'd15:   t = 34'sd20861;
      5'd16:   t = 34'sd10430;
      5'd17:   t = 34'sd5215;
      5'd18:   t = 34'sd2608;
      5'd19:   t = 34'sd1304;
      5'd20:   t = 34'sd652;
      5'd21:   t = 34'sd326;
      5'd22:   t = 34'sd163;
      5'd23:   t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/q2e_quat_if.sv @@
// ---------------------------------------------------------------------------
// q2e_quat_if
// Valid/ready channel carrying one Q2.14 quaternion per word.
// ---------------------------------------------------------------------------
interface q2e_quat_if;
  logic                           valid;
  logic                           ready;
  logic signed [q2e_pkg::QW-1:0]  quat_w;
  logic signed [q2e_pkg::QW-1:0]  quat_x;
  logic signed [q2e_pkg::QW-1:0]  quat_y;
  logic signed [q2e_pkg::QW-1:0]  quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

@@ rtl/q2e_euler_if.sv @@
// ---------------------------------------------------------------------------
// q2e_euler_if
// Valid/ready channel carrying three 8-bit angle codes per word.
// ---------------------------------------------------------------------------
interface q2e_euler_if;
  logic       valid;
  logic       ready;
  logic [7:0] roll_code;
  logic [7:0] pitch_code;
  logic [7:0] yaw_code;

  modport source (output valid, output roll_code, output pitch_code,
                  output yaw_code, input ready);
  modport sink   (input valid, input roll_code, input pitch_code,
                  input yaw_code, output ready);
endinterface

@@ rtl/quaternion_to_euler_codes.sv @@
// ---------------------------------------------------------------------------
// quaternion_to_euler_codes
// Converts a Q2.14 orientation quaternion into 8-bit roll, pitch and yaw
// codes (ZYX convention) through a fully pipelined datapath.
// ---------------------------------------------------------------------------
// usage:
//   in_quat   : valid/ready sink, one quaternion (w, x, y, z) per word
//   out_euler : valid/ready source, roll_code, pitch_code, yaw_code per word
//   stages    : 4 product stages, 29 square root stages, 1 + CORDIC_STAGES
//               cordic stages and 2 code stages
//   throughput: one word per cycle unless the output stalls; every stage is
//               a register stage; square root and cordic unroll one stage per step
//   stall     : the whole pipeline advances together; when the output word
//               is held and not taken, in_quat.ready drops and every stage
//               keeps its contents, so nothing is dropped or repeated
//   reset     : synchronous rst_n clears all valid bits; no words in flight
//   no renormalization: the pitch term saturates at +-1.0
// ---------------------------------------------------------------------------
module quaternion_to_euler_codes #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  q2e_quat_if.sink           in_quat,
  q2e_euler_if.source        out_euler
);

  localparam int CW    = q2e_pkg::CW;
  localparam int AW    = q2e_pkg::AW;
  localparam int RW    = q2e_pkg::RW;
  localparam int LANES = q2e_pkg::LANES;

  localparam logic signed [AW-1:0] HALF_P    = AW'(64'sd2147483648);
  localparam logic signed [AW-1:0] HALF_N    = AW'(-64'sd2147483648);
  localparam logic signed [AW-1:0] QUARTER_P = AW'(64'sd1073741824);
  localparam logic signed [AW-1:0] QUARTER_N = AW'(-64'sd1073741824);

  // global advance: move when the output slot is free or being taken
  logic en;
  logic out_valid_r;
  assign en            = !out_valid_r || out_euler.ready;
  assign in_quat.ready = en;

  // products and radicand
  logic                  prod_vld;
  logic [q2e_pkg::NW-1:0] prod_rad;
  q2e_pkg::side_t        prod_side;

  q2e_prod u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_quat.valid),
    .w       (in_quat.quat_w),
    .x       (in_quat.quat_x),
    .y       (in_quat.quat_y),
    .z       (in_quat.quat_z),
    .out_vld (prod_vld),
    .rad     (prod_rad),
    .side    (prod_side)
  );

  // square root of 1 - s^2
  logic                  sq_vld;
  logic [RW-1:0]         sq_root;
  q2e_pkg::side_t        sq_side;

  q2e_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (prod_vld),
    .rad      (prod_rad),
    .in_side  (prod_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // cordic lane inputs
  logic signed [CW-1:0] vec_x [LANES];
  logic signed [CW-1:0] vec_y [LANES];
  logic signed [AW-1:0] ang   [LANES];
  logic                 cord_vld;

  assign vec_y[q2e_pkg::LANE_ROLL]  = CW'(sq_side.roll_num);
  assign vec_x[q2e_pkg::LANE_ROLL]  = CW'(sq_side.roll_den);
  assign vec_y[q2e_pkg::LANE_PITCH] = CW'(sq_side.pitch_s);
  assign vec_x[q2e_pkg::LANE_PITCH] = CW'({1'b0, sq_root});
  assign vec_y[q2e_pkg::LANE_YAW]   = CW'(sq_side.yaw_num);
  assign vec_x[q2e_pkg::LANE_YAW]   = CW'(sq_side.yaw_den);

  q2e_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .vec_x   (vec_x),
    .vec_y   (vec_y),
    .out_vld (cord_vld),
    .ang     (ang)
  );

  // clamp and offset the angles
  logic                 code_vld_r;
  logic [32:0]          roll_u_r, yaw_u_r;
  logic [31:0]          pitch_u_r;
  logic signed [AW-1:0] roll_c, yaw_c, pitch_c;
  logic signed [AW-1:0] roll_o, yaw_o, pitch_o;

  always_comb begin
    roll_c  = (ang[q2e_pkg::LANE_ROLL] > HALF_P) ? HALF_P :
              (ang[q2e_pkg::LANE_ROLL] < HALF_N) ? HALF_N : ang[q2e_pkg::LANE_ROLL];
    yaw_c   = (ang[q2e_pkg::LANE_YAW] > HALF_P) ? HALF_P :
              (ang[q2e_pkg::LANE_YAW] < HALF_N) ? HALF_N : ang[q2e_pkg::LANE_YAW];
    pitch_c = (ang[q2e_pkg::LANE_PITCH] > QUARTER_P) ? QUARTER_P :
              (ang[q2e_pkg::LANE_PITCH] < QUARTER_N) ? QUARTER_N : ang[q2e_pkg::LANE_PITCH];
    roll_o  = roll_c + HALF_P;
    yaw_o   = yaw_c + HALF_P;
    pitch_o = pitch_c + QUARTER_P;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_vld_r <= 1'b0;
    end else if (en) begin
      code_vld_r <= cord_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_u_r  <= roll_o[32:0];
      yaw_u_r   <= yaw_o[32:0];
      pitch_u_r <= pitch_o[31:0];
    end
  end

  // scale by 255 and keep the top code bits
  logic [40:0] roll_p, yaw_p;
  logic [39:0] pitch_p;
  logic [7:0]  roll_r, pitch_r, yaw_r;

  assign roll_p  = {roll_u_r, 8'd0} - {8'd0, roll_u_r};
  assign yaw_p   = {yaw_u_r, 8'd0} - {8'd0, yaw_u_r};
  assign pitch_p = {pitch_u_r, 8'd0} - {8'd0, pitch_u_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= code_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_p[39:32];
      yaw_r   <= yaw_p[39:32];
      pitch_r <= pitch_p[38:31];
    end
  end

  assign out_euler.valid      = out_valid_r;
  assign out_euler.roll_code  = roll_r;
  assign out_euler.pitch_code = pitch_r;
  assign out_euler.yaw_code   = yaw_r;

  // reset leaves no word at the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_euler.valid)
    else $error("output valid after reset");

  // a finished code word moves into the output register when advancing
  a_code_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && code_vld_r |=> out_valid_r)
    else $error("code word lost before output");

  // a stall freezes the cordic-to-code hand-off
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(code_vld_r) && $stable(roll_u_r) && $stable(pitch_u_r))
    else $error("pipeline moved during stall");

endmodule

@@ rtl/q2e_prod.sv @@
// ---------------------------------------------------------------------------
// q2e_prod
// Four stages: component products, atan2 terms and clamped pitch term,
// square of the pitch term, radicand 1 - s^2 for the square root.
// ---------------------------------------------------------------------------
module q2e_prod (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [q2e_pkg::QW-1:0]       w,
  input  logic signed [q2e_pkg::QW-1:0]       x,
  input  logic signed [q2e_pkg::QW-1:0]       y,
  input  logic signed [q2e_pkg::QW-1:0]       z,
  output logic                                out_vld,
  output logic [q2e_pkg::NW-1:0]              rad,
  output q2e_pkg::side_t                      side
);

  localparam int PW = q2e_pkg::PW;
  localparam int VW = q2e_pkg::VW;
  localparam int SW = q2e_pkg::SW;
  localparam int NW = q2e_pkg::NW;
  localparam int RW = q2e_pkg::RW;

  localparam logic signed [VW-1:0] ONE_Q28 = VW'(64'sd268435456);
  localparam logic signed [VW-1:0] NEG_Q28 = VW'(-64'sd268435456);

  // stage a: products
  logic               a_vld_r;
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= PW'(w) * PW'(x);
      yz_r <= PW'(y) * PW'(z);
      xx_r <= PW'(x) * PW'(x);
      yy_r <= PW'(y) * PW'(y);
      wz_r <= PW'(w) * PW'(z);
      xy_r <= PW'(x) * PW'(y);
      zz_r <= PW'(z) * PW'(z);
      wy_r <= PW'(w) * PW'(y);
      zx_r <= PW'(z) * PW'(x);
    end
  end

  // stage b: atan2 terms and clamped pitch term
  logic                 b_vld_r;
  q2e_pkg::side_t       b_side_r;
  q2e_pkg::side_t       b_side_nxt;
  logic signed [VW-1:0] s_full;

  always_comb begin
    b_side_nxt.roll_num = (VW'(wx_r) + VW'(yz_r)) <<< 1;
    b_side_nxt.roll_den = ONE_Q28 - ((VW'(xx_r) + VW'(yy_r)) <<< 1);
    b_side_nxt.yaw_num  = (VW'(wz_r) + VW'(xy_r)) <<< 1;
    b_side_nxt.yaw_den  = ONE_Q28 - ((VW'(yy_r) + VW'(zz_r)) <<< 1);
    s_full              = (VW'(wy_r) - VW'(zx_r)) <<< 1;
    priority if (s_full > ONE_Q28) begin
      b_side_nxt.pitch_s = SW'(ONE_Q28);
    end else if (s_full < NEG_Q28) begin
      b_side_nxt.pitch_s = SW'(NEG_Q28);
    end else begin
      b_side_nxt.pitch_s = SW'(s_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= b_side_nxt;
    end
  end

  // stage c: square of the pitch term
  logic                 c_vld_r;
  q2e_pkg::side_t       c_side_r;
  logic [NW-1:0]        c_sq_r;
  logic [RW-1:0]        s_mag;

  assign s_mag = b_side_r.pitch_s[SW-1] ? RW'(-b_side_r.pitch_s) : b_side_r.pitch_s[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= b_side_r;
      c_sq_r   <= NW'(s_mag) * NW'(s_mag);
    end
  end

  // stage d: radicand 2^56 - s^2
  logic                 d_vld_r;
  q2e_pkg::side_t       d_side_r;
  logic [NW-1:0]        d_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= c_side_r;
      d_rad_r  <= (NW'(1) << 56) - c_sq_r;
    end
  end

  assign out_vld = d_vld_r;
  assign rad     = d_rad_r;
  assign side    = d_side_r;

endmodule

@@ rtl/q2e_isqrt.sv @@
// ---------------------------------------------------------------------------
// q2e_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// The atan2 terms ride along beside it.
// ---------------------------------------------------------------------------
module q2e_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [q2e_pkg::NW-1:0]        rad,
  input  q2e_pkg::side_t                in_side,
  output logic                          out_vld,
  output logic [q2e_pkg::RW-1:0]        root,
  output q2e_pkg::side_t                out_side
);

  localparam int NW    = q2e_pkg::NW;
  localparam int RW    = q2e_pkg::RW;
  localparam int STEPS = q2e_pkg::ISQ_STEPS;

  logic                 vld_r  [STEPS+1];
  logic [NW-1:0]        rem_r  [STEPS+1];
  logic [NW-1:0]        root_r [STEPS+1];
  q2e_pkg::side_t       side_r [STEPS+1];

  // stage entry
  assign vld_r[0]  = in_vld;
  assign rem_r[0]  = rad;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (STEPS - 1 - j));
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_nxt;
    logic [NW-1:0] root_nxt;

    // compare and subtract for one result bit
    always_comb begin
      trial = root_r[j] + BIT;
      if (rem_r[j] >= trial) begin
        rem_nxt  = rem_r[j] - trial;
        root_nxt = (root_r[j] >> 1) + BIT;
      end else begin
        rem_nxt  = rem_r[j];
        root_nxt = root_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= rem_nxt;
        root_r[j+1] <= root_nxt;
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign root     = root_r[STEPS][RW-1:0];
  assign out_side = side_r[STEPS];

endmodule

@@ rtl/q2e_cordic.sv @@
// ---------------------------------------------------------------------------
// q2e_cordic
// Three-lane vectoring cordic: quadrant pre-rotation stage, then one
// micro-rotation per stage. Gives atan2(y, x) as a binary angle.
// ---------------------------------------------------------------------------
module q2e_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [q2e_pkg::CW-1:0]       vec_x [q2e_pkg::LANES],
  input  logic signed [q2e_pkg::CW-1:0]       vec_y [q2e_pkg::LANES],
  output logic                                out_vld,
  output logic signed [q2e_pkg::AW-1:0]       ang   [q2e_pkg::LANES]
);

  localparam int CW    = q2e_pkg::CW;
  localparam int AW    = q2e_pkg::AW;
  localparam int LANES = q2e_pkg::LANES;

  localparam logic signed [AW-1:0] QUARTER = AW'(64'sd1073741824);

  logic                 vld_r  [STAGES+1];
  logic signed [CW-1:0] x_r    [LANES][STAGES+1];
  logic signed [CW-1:0] y_r    [LANES][STAGES+1];
  logic signed [AW-1:0] ang_r  [LANES][STAGES+1];
  logic                 zero_r [LANES][STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // quadrant pre-rotation into the right half plane
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[l][0] <= (vec_x[l] == '0) && (vec_y[l] == '0);
        if (vec_x[l] < 0) begin
          if (vec_y[l] >= 0) begin
            x_r[l][0]   <= vec_y[l];
            y_r[l][0]   <= -vec_x[l];
            ang_r[l][0] <= QUARTER;
          end else begin
            x_r[l][0]   <= -vec_y[l];
            y_r[l][0]   <= vec_x[l];
            ang_r[l][0] <= -QUARTER;
          end
        end else begin
          x_r[l][0]   <= vec_x[l];
          y_r[l][0]   <= vec_y[l];
          ang_r[l][0] <= '0;
        end
      end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      assign xs = x_r[l][g] >>> g;
      assign ys = y_r[l][g] >>> g;

      // one micro-rotation toward y = 0
      always_ff @(posedge clk) begin
        if (en) begin
          zero_r[l][g+1] <= zero_r[l][g];
          if (y_r[l][g] < 0) begin
            x_r[l][g+1]   <= x_r[l][g] - ys;
            y_r[l][g+1]   <= y_r[l][g] + xs;
            ang_r[l][g+1] <= ang_r[l][g] - q2e_pkg::atan_tab(5'(g));
          end else begin
            x_r[l][g+1]   <= x_r[l][g] + ys;
            y_r[l][g+1]   <= y_r[l][g] - xs;
            ang_r[l][g+1] <= ang_r[l][g] + q2e_pkg::atan_tab(5'(g));
          end
        end
      end
    end

    // zero vector gives angle zero
    assign ang[l] = zero_r[l][STAGES] ? '0 : ang_r[l][STAGES];
  end

  assign out_vld = vld_r[STAGES];

endmodule

@@ tb/tb_quaternion_to_euler_codes.sv @@
// ---------------------------------------------------------------------------
// tb_quaternion_to_euler_codes
// Drives quaternion words into the converter with random idling on both
// sides and checks each angle-code word against a bit-exact predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_to_euler_codes;

  localparam int STAGES    = 16;
  localparam int LATENCY   = STAGES + 36;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [7:0] roll;
    logic [7:0] pitch;
    logic [7:0] yaw;
  } codes_t;

  logic clk;
  logic rst_n;
  q2e_quat_if  quat_ch ();
  q2e_euler_if euler_ch ();

  quaternion_to_euler_codes #(.CORDIC_STAGES(STAGES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_quat  (quat_ch.sink),
    .out_euler(euler_ch.source)
  );

  codes_t      codes_pending[$];
  int          errors;
  int          cycle;
  bit          calm;       // no idling on either side
  int          idle_pct;
  longint      atan_lut[24];

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331,
                 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                 333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                 1304, 652, 326, 163, 81};
  end

  // floor shift for signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(root);
  endfunction

  // vectoring arctangent, binary angle with pi = 2^31
  function automatic longint vec_atan2(longint y, longint x);
    longint ang, t, xs, ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 64'sd1 << 30;
      end else begin
        t = x; x = -y; y = t; ang = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y < 0) begin
        x -= ys; y += xs; ang -= atan_lut[i];
      end else begin
        x += ys; y -= xs; ang += atan_lut[i];
      end
    end
    if (ang > (64'sd1 << 31)) ang = 64'sd1 << 31;
    if (ang < -(64'sd1 << 31)) ang = -(64'sd1 << 31);
    return ang;
  endfunction

  function automatic codes_t euler_codes(longint w, longint x, longint y, longint z);
    codes_t r;
    longint one, ar, ay, ap, s, c;
    one = 64'sd1 << 28;
    ar = vec_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y));
    ay = vec_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    s = 2 * (w * y - z * x);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = int_sqrt(longint'(one * one - s * s));
    ap = vec_atan2(s, c);
    if (ap > (64'sd1 << 30)) ap = 64'sd1 << 30;
    if (ap < -(64'sd1 << 30)) ap = -(64'sd1 << 30);
    r.roll  = 8'(((ar + (64'sd1 << 31)) * 255) >>> 32);
    r.pitch = 8'(((ap + (64'sd1 << 30)) * 255) >>> 31);
    r.yaw   = 8'(((ay + (64'sd1 << 31)) * 255) >>> 32);
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("timeout at %0t", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result-side ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) euler_ch.ready <= 1'b0;
    else euler_ch.ready <= calm || ($urandom_range(99) >= idle_pct);
  end

  // check each accepted word against the oldest prediction
  always @(posedge clk) begin
    codes_t exp_c;
    if (rst_n && euler_ch.valid && euler_ch.ready) begin
      if (codes_pending.size() == 0) begin
        $display("%0t unexpected word r=%0d p=%0d y=%0d", $time,
                 euler_ch.roll_code, euler_ch.pitch_code, euler_ch.yaw_code);
        errors++;
      end else begin
        exp_c = codes_pending.pop_front();
        if (euler_ch.roll_code !== exp_c.roll) begin
          $display("%0t roll exp %0d got %0d", $time, exp_c.roll, euler_ch.roll_code);
          errors++;
        end
        if (euler_ch.pitch_code !== exp_c.pitch) begin
          $display("%0t pitch exp %0d got %0d", $time, exp_c.pitch,
                   euler_ch.pitch_code);
          errors++;
        end
        if (euler_ch.yaw_code !== exp_c.yaw) begin
          $display("%0t yaw exp %0d got %0d", $time, exp_c.yaw, euler_ch.yaw_code);
          errors++;
        end
      end
    end
  end

  // send one quaternion word, with a random idle gap first
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    while (!calm && $urandom_range(99) < idle_pct) begin
      quat_ch.valid <= 1'b0;
      @(posedge clk);
    end
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_w <= w;
    quat_ch.quat_x <= x;
    quat_ch.quat_y <= y;
    quat_ch.quat_z <= z;
    codes_pending.push_back(euler_codes(longint'($signed(w)), longint'($signed(x)),
                                        longint'($signed(y)), longint'($signed(z))));
    @(posedge clk);
    while (!quat_ch.ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 16'($signed($urandom_range(32768)) - 16384);
    if (r < 90) return 16'($urandom);
    return (r & 1) ? 16'sd16384 : -16'sd16384;
  endfunction

  // stop sending and wait for every outstanding word
  task automatic wait_drain();
    quat_ch.valid <= 1'b0;
    @(posedge clk);
    while (codes_pending.size() != 0) @(posedge clk);
  endtask

  // extremes, zero vector, axis rotations and gimbal points
  task automatic test_directed();
    send_quat(16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 0, 0, -11585);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'hffff, 16'h0001, 16'h5555, 16'haaaa);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, -8192);
    send_quat(0, 0, 0, -16384);
    send_quat(0, -16384, 0, 0);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 1, -1);
  endtask

  // random unit-ish quaternions and raw noise with idling
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1200) wait_drain();
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    calm = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    cycle = 0;
    calm = 1'b0;
    idle_pct = 8;
    quat_ch.valid  <= 1'b0;
    quat_ch.quat_w <= '0;
    quat_ch.quat_x <= '0;
    quat_ch.quat_y <= '0;
    quat_ch.quat_z <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_random(1830);
    wait_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
